// File: sv/psf_pkg.sv
package psf_pkg;

  // Default edge length of the cubic lattice.
  localparam int SIDE_DEF = 16;

  // Fixed field widths.
  localparam int SITE_W  = 12;
  localparam int E_W     = 18;
  localparam int DE_W    = 6;
  localparam int CNT_W   = 32;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 1;

  // Rows fetched around a site: the center row and eight neighbors in y and z.
  localparam int NUM_SLOTS = 9;
  localparam int SLOT_W    = 4;

  localparam logic signed [E_W-1:0] E_MIN = -18'sd131072;
  localparam logic signed [E_W-1:0] E_MAX = 18'sd131071;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROBE   = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_E = 1'b0,
    CFG_MAX_E = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              init_wr;
    logic              dec1;
    logic              dec2;
    logic              dec3;
    logic              fetch_issue;
    logic              fetch_capture;
    logic [SLOT_W-1:0] fetch_k;
    logic              sum;
    logic              add;
    logic              decide;
  } psf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic is_load;
    logic site_ok;
    logic out_free;
  } psf_stat_t;

  // Row offset in y for each fetch slot.
  function automatic int slot_dy(logic [SLOT_W-1:0] k);
    int r;
    case (k)
      4'd1, 4'd5, 4'd8: r = 1;
      4'd2, 4'd6, 4'd7: r = -1;
      default:          r = 0;
    endcase
    return r;
  endfunction

  // Row offset in z for each fetch slot.
  function automatic int slot_dz(logic [SLOT_W-1:0] k);
    int r;
    case (k)
      4'd3, 4'd5, 4'd7: r = 1;
      4'd4, 4'd6, 4'd8: r = -1;
      default:          r = 0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/psf_if.sv
// Request channel: one word per command.
interface psf_in_if
  import psf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [SITE_W-1:0]        site;
  logic                     accept;
  logic signed [E_W-1:0]    energy_value;

  modport source (output valid, command, site, accept, energy_value, input ready);
  modport sink   (input valid, command, site, accept, energy_value, output ready);
endinterface

// Result channel: one word per request.
interface psf_out_if
  import psf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DE_W-1:0]   delta_energy_half;
  logic signed [E_W-1:0]    new_energy_half;
  logic                     in_window;
  logic                     flipped;
  logic [CNT_W-1:0]         attempt_count;
  logic [CNT_W-1:0]         accept_count;

  modport source (output valid, delta_energy_half, new_energy_half, in_window, flipped,
                  attempt_count, accept_count, input ready);
  modport sink   (input valid, delta_energy_half, new_energy_half, in_window, flipped,
                  attempt_count, accept_count, output ready);
endinterface

// File: sv/psf_ctrl.sv
module psf_ctrl
  import psf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_accept_i,
  input  psf_stat_t stat_i,
  output logic      in_ready_o,
  output psf_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DEC1   = 9'b000000100,
    ST_DEC2   = 9'b000001000,
    ST_DEC3   = 9'b000010000,
    ST_FETCH  = 9'b000100000,
    ST_SUM    = 9'b001000000,
    ST_ADD    = 9'b010000000,
    ST_DECIDE = 9'b100000000
  } state_e;

  localparam logic [SLOT_W-1:0] LAST_K = SLOT_W'(NUM_SLOTS);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] fetch_cnt_q, fetch_cnt_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    fetch_cnt_d = fetch_cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept_i) begin
          state_d = ST_DEC1;
        end
      end
      ST_DEC1: begin
        cmd_o.dec1 = 1'b1;
        // Loads and sites outside the box need no neighborhood.
        if (stat_i.is_load || !stat_i.site_ok) begin
          state_d = ST_ADD;
        end else begin
          state_d = ST_DEC2;
        end
      end
      ST_DEC2: begin
        cmd_o.dec2 = 1'b1;
        state_d    = ST_DEC3;
      end
      ST_DEC3: begin
        cmd_o.dec3  = 1'b1;
        fetch_cnt_d = '0;
        state_d     = ST_FETCH;
      end
      ST_FETCH: begin
        // One row read issued per cycle; its data is captured in the next cycle.
        cmd_o.fetch_k       = fetch_cnt_q;
        cmd_o.fetch_issue   = (fetch_cnt_q != LAST_K);
        cmd_o.fetch_capture = (fetch_cnt_q != '0);
        fetch_cnt_d         = fetch_cnt_q + SLOT_W'(1);
        if (fetch_cnt_q == LAST_K) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      fetch_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      fetch_cnt_q <= fetch_cnt_d;
    end
  end

endmodule

// File: sv/psf_dp.sv
module psf_dp
  import psf_pkg::*;
#(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  psf_cmd_t                 cmd_i,
  output psf_stat_t                stat_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [E_W-1:0]           cfg_data_i,
  input  logic                     in_accept_i,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [SITE_W-1:0]        site_i,
  input  logic                     accept_i,
  input  logic signed [E_W-1:0]    energy_value_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [DE_W-1:0]   delta_energy_half_o,
  output logic signed [E_W-1:0]    new_energy_half_o,
  output logic                     in_window_o,
  output logic                     flipped_o,
  output logic [CNT_W-1:0]         attempt_count_o,
  output logic [CNT_W-1:0]         accept_count_o
);

  localparam int CW     = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int ROWS   = SIDE * SIDE;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int VOLUME = SIDE * SIDE * SIDE;
  // Reciprocal for exact division of values below 2^SITE_W by SIDE.
  localparam int DIV_SH = 20;
  localparam int RECIP  = ((1 << DIV_SH) + SIDE - 1) / SIDE;
  localparam int PROD_W = SITE_W + DIV_SH + 1;
  localparam logic [SIDE-1:0] INIT_ROW = SIDE'((64'd1 << (SIDE / 2)) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request word.
  logic [CMD_W-1:0]      cmd_q;
  logic [SITE_W-1:0]     site_q;
  logic                  acc_q;
  logic signed [E_W-1:0] ev_q;

  // Site decomposition.
  logic [ROW_W-1:0]  row_q;
  logic [CW-1:0]     x_q, y_q, z_q;
  logic [PROD_W-1:0] prod_row, prod_z;
  logic [SITE_W:0]   x_full, y_full;

  // Lattice memory and fetch pipeline.
  logic [SIDE-1:0]   mem [ROWS];
  logic [SIDE-1:0]   rd_q;
  logic [ROW_W-1:0]  init_cnt_q;
  logic [ROW_W-1:0]  rd_addr, wr_addr;
  logic [SIDE-1:0]   wr_data;
  logic              wr_en;
  int                dy, dz;
  logic              oob;
  logic [SLOT_W-1:0] slot_p_q;
  logic              oob_p_q;
  logic [CW-1:0]     xm1, xp1;
  logic [2:0]        cap_bits;
  logic [2:0]        wnd_q [NUM_SLOTS];
  logic [SIDE-1:0]   crow_q;

  // Energy and decision.
  logic [11:0]            prods;
  logic [3:0]             n_pos;
  logic signed [6:0]      s4, s4n;
  logic signed [DE_W-1:0] delta_d, delta_q;
  logic signed [E_W:0]    sum19;
  logic signed [E_W-1:0]  newe_d, newe_q;
  logic signed [E_W-1:0]  energy_q;
  logic signed [E_W-1:0]  min_q, max_q;
  logic                   win, flip;

  // Output register.
  logic                   out_valid_q;
  logic signed [DE_W-1:0] o_delta_q;
  logic signed [E_W-1:0]  o_newe_q;
  logic                   o_win_q, o_flip_q;
  logic [CNT_W-1:0]       attempts_q, accepts_q;

  // Status toward the controller.
  always_comb begin
    stat_o.init_last = (init_cnt_q == ROW_W'(ROWS - 1));
    stat_o.is_load   = (cmd_q == CMD_LOAD);
    stat_o.site_ok   = ({20'd0, site_q} < 32'(VOLUME));
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Latch the request word.
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      cmd_q  <= command_i;
      site_q <= site_i;
      acc_q  <= accept_i;
      ev_q   <= energy_value_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= E_MIN;
      max_q <= E_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_E: min_q <= cfg_data_i;
        CFG_MAX_E: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Split the site into row (y + SIDE*z) and x, then the row into y and z.
  assign prod_row = PROD_W'(site_q) * PROD_W'(RECIP);
  assign prod_z   = PROD_W'(row_q) * PROD_W'(RECIP);
  assign x_full   = (SITE_W + 1)'(site_q) - (SITE_W + 1)'(row_q * SIDE);
  assign y_full   = (SITE_W + 1)'(row_q) - (SITE_W + 1)'(z_q * SIDE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec1) begin
      row_q <= prod_row[DIV_SH +: ROW_W];
    end
    if (cmd_i.dec2) begin
      x_q <= x_full[CW-1:0];
      z_q <= prod_z[DIV_SH +: CW];
    end
    if (cmd_i.dec3) begin
      y_q <= y_full[CW-1:0];
    end
  end

  // Fetch address and box test for the current slot.
  always_comb begin
    dy      = slot_dy(cmd_i.fetch_k);
    dz      = slot_dz(cmd_i.fetch_k);
    oob     = (dy == 1 && y_q == CW'(SIDE - 1)) || (dy == -1 && y_q == '0) ||
              (dz == 1 && z_q == CW'(SIDE - 1)) || (dz == -1 && z_q == '0);
    rd_addr = ROW_W'(int'(row_q) + dy + SIDE * dz);
  end

  // Memory write port: the reset sweep or the flip write-back.
  always_comb begin
    if (cmd_i.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = init_cnt_q;
      wr_data = INIT_ROW;
    end else begin
      wr_en   = cmd_i.decide && flip;
      wr_addr = row_q;
      wr_data = crow_q ^ (SIDE'(1) << x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
    end else if (cmd_i.init_wr) begin
      init_cnt_q <= init_cnt_q + ROW_W'(1);
    end
  end

  // Slot tag travels with the read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_issue) begin
      slot_p_q <= cmd_i.fetch_k;
      oob_p_q  <= oob;
    end
  end

  // Take x-1, x and x+1 out of the returned row; the outside is +1.
  always_comb begin
    xm1 = x_q - CW'(1);
    xp1 = x_q + CW'(1);
    if (oob_p_q) begin
      cap_bits = 3'b111;
    end else begin
      cap_bits[0] = (x_q == '0) ? 1'b1 : rd_q[xm1];
      cap_bits[1] = rd_q[x_q];
      cap_bits[2] = (x_q == CW'(SIDE - 1)) ? 1'b1 : rd_q[xp1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_capture) begin
      wnd_q[slot_p_q] <= cap_bits;
      if (slot_p_q == '0) begin
        crow_q <= rd_q;
      end
    end
  end

  // Plaquette products: a product of three spins is +1 when the XOR of their bits is 1.
  always_comb begin
    prods[0]  = wnd_q[0][2] ^ wnd_q[1][2] ^ wnd_q[1][1];
    prods[1]  = wnd_q[0][0] ^ wnd_q[1][0] ^ wnd_q[1][1];
    prods[2]  = wnd_q[0][0] ^ wnd_q[2][0] ^ wnd_q[2][1];
    prods[3]  = wnd_q[0][2] ^ wnd_q[2][2] ^ wnd_q[2][1];
    prods[4]  = wnd_q[0][2] ^ wnd_q[3][2] ^ wnd_q[3][1];
    prods[5]  = wnd_q[0][0] ^ wnd_q[3][0] ^ wnd_q[3][1];
    prods[6]  = wnd_q[0][0] ^ wnd_q[4][0] ^ wnd_q[4][1];
    prods[7]  = wnd_q[0][2] ^ wnd_q[4][2] ^ wnd_q[4][1];
    prods[8]  = wnd_q[1][1] ^ wnd_q[5][1] ^ wnd_q[3][1];
    prods[9]  = wnd_q[2][1] ^ wnd_q[6][1] ^ wnd_q[4][1];
    prods[10] = wnd_q[2][1] ^ wnd_q[7][1] ^ wnd_q[3][1];
    prods[11] = wnd_q[1][1] ^ wnd_q[8][1] ^ wnd_q[4][1];
    n_pos     = 4'($countones(prods));
    // Twice the plaquette sum: 2*(2n - 12), signed by the center spin.
    s4        = $signed({1'b0, n_pos, 2'b00}) - 7'sd24;
    s4n       = -s4;
    delta_d   = wnd_q[0][1] ? s4[DE_W-1:0] : s4n[DE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec1) begin
      delta_q <= '0;
    end else if (cmd_i.sum) begin
      delta_q <= delta_d;
    end
  end

  // New energy with saturation, or the loaded value.
  always_comb begin
    sum19 = {energy_q[E_W-1], energy_q} + (E_W + 1)'(delta_q);
    if (cmd_q == CMD_LOAD) begin
      newe_d = ev_q;
    end else if (sum19 > (E_W + 1)'(E_MAX)) begin
      newe_d = E_MAX;
    end else if (sum19 < (E_W + 1)'(E_MIN)) begin
      newe_d = E_MIN;
    end else begin
      newe_d = sum19[E_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      newe_q <= newe_d;
    end
  end

  // Window test and flip decision.
  assign win  = (newe_q >= min_q) && (newe_q <= max_q);
  assign flip = (cmd_q == CMD_RESOLVE) && stat_o.site_ok && win && acc_q;

  // Running energy and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q   <= '0;
      attempts_q <= '0;
      accepts_q  <= '0;
    end else if (cmd_i.decide) begin
      if (cmd_q == CMD_LOAD || flip) begin
        energy_q <= newe_q;
      end
      if (cmd_q == CMD_RESOLVE && attempts_q != CNT_MAX) begin
        attempts_q <= attempts_q + CNT_W'(1);
      end
      if (flip && accepts_q != CNT_MAX) begin
        accepts_q <= accepts_q + CNT_W'(1);
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      o_delta_q <= delta_q;
      o_newe_q  <= newe_q;
      o_win_q   <= win;
      o_flip_q  <= flip;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign delta_energy_half_o = o_delta_q;
  assign new_energy_half_o   = o_newe_q;
  assign in_window_o         = o_win_q;
  assign flipped_o           = o_flip_q;
  assign attempt_count_o     = attempts_q;
  assign accept_count_o      = accepts_q;

endmodule

// File: sv/plaquette_spin_flip_update_core.sv
// Plaquette spin-flip update core.
// Holds a SIDE^3 lattice of +1/-1 spins (boundary fixed at +1), a running energy in half
// units and two saturating counters. Each request word on in_ch_i carries a command
// (probe, resolve, load), a site, an accept bit and a load value; each request gives
// exactly one result word on out_ch_o. Window bounds are written on the cfg_* port; the
// user writes them only while the core is idle, and the core does not enforce this.
// Flow: a probe or resolve of a site inside the box steps through the states DEC1, DEC2,
// DEC3, FETCH, SUM, ADD and DECIDE; the core takes one request at a time and is ready
// again only after DECIDE. The lattice memory has a single read port: nine rows (the
// site's row and its eight y/z neighbors) are read in FETCH one per cycle. Loads and
// sites outside the box go from DEC1 straight to ADD and DECIDE, skipping the fetch.
// Reset: the lattice memory is swept one row per cycle over all SIDE*SIDE rows (256 at
// the default size), during which in_ch_i.ready stays low.
// Stall: the result sits in an output register; a new request is accepted while it
// waits, and that request's result is held back until out_ch_o.ready frees the register.
module plaquette_spin_flip_update_core
  import psf_pkg::*;
#(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  psf_in_if.sink                in_ch_i,
  psf_out_if.source             out_ch_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [E_W-1:0]        cfg_data_i
);

  psf_cmd_t  cmd;
  psf_stat_t stat;
  logic      in_ready;
  logic      in_accept;

  assign in_ch_i.ready = in_ready;
  assign in_accept     = in_ch_i.valid && in_ready;

  psf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  psf_dp #(
    .SIDE (SIDE)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_accept_i         (in_accept),
    .command_i           (in_ch_i.command),
    .site_i              (in_ch_i.site),
    .accept_i            (in_ch_i.accept),
    .energy_value_i      (in_ch_i.energy_value),
    .out_ready_i         (out_ch_o.ready),
    .out_valid_o         (out_ch_o.valid),
    .delta_energy_half_o (out_ch_o.delta_energy_half),
    .new_energy_half_o   (out_ch_o.new_energy_half),
    .in_window_o         (out_ch_o.in_window),
    .flipped_o           (out_ch_o.flipped),
    .attempt_count_o     (out_ch_o.attempt_count),
    .accept_count_o      (out_ch_o.accept_count)
  );

`ifndef NO_ASSERTIONS
  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && !out_ch_o.ready) |-> !cmd.decide)
    else $error("result register overwritten while stalled");

  // One request at a time: ready drops right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ch_i.ready)
    else $error("request accepted while another is in flight");

  // Every captured row was requested in the cycle before.
  a_capture_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fetch_capture |-> $past(cmd.fetch_issue))
    else $error("row captured without a read issued");
`endif

endmodule

// File: verif/tb_plaquette_spin_flip_update_core.sv
`timescale 1ns / 1ps

module tb_plaquette_spin_flip_update_core;
  import psf_pkg::*;

  localparam int SIDE      = SIDE_DEF;
  localparam int VOLUME    = SIDE * SIDE * SIDE;
  localparam int CYCLE_CAP = 500000;
  localparam int LO_E      = -131072;
  localparam int HI_E      = 131071;

  typedef struct {
    cmd_e                  cmd;
    logic [SITE_W-1:0]     site;
    logic                  accept;
    logic signed [E_W-1:0] energy;
  } request_t;

  typedef struct {
    logic signed [DE_W-1:0] delta;
    logic signed [E_W-1:0]  energy;
    logic                   win;
    logic                   flip;
    logic [CNT_W-1:0]       attempts;
    logic [CNT_W-1:0]       accepts;
  } result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [E_W-1:0]       cfg_data_i;

  psf_in_if  in_ch ();
  psf_out_if out_ch ();

  plaquette_spin_flip_update_core #(
    .SIDE(SIDE)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch_i   (in_ch),
    .out_ch_o  (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the lattice, the running energy, the counters and the window.
  bit               spin_up [VOLUME];
  int               model_energy;
  logic [CNT_W-1:0] model_attempts;
  logic [CNT_W-1:0] model_accepts;
  int               win_lo;
  int               win_hi;

  request_t pending_requests [$];
  result_t  expected_results [$];
  request_t drv_req;
  result_t  exp_res;

  int  src_gap;
  int  sink_gap;
  bit  idling_on;
  int  error_count;
  int  cycle_count;
  int  n_probe;
  int  n_resolve;
  int  n_load;
  int  n_flip;
  int  n_checked;
  int  n_windows;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Spin at a coordinate; everything outside the box is a fixed up spin.
  function automatic int spin_of(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE) return 1;
    return spin_up[x + SIDE * y + SIDE * SIDE * z] ? 1 : -1;
  endfunction

  // Energy change in half units of flipping one site: twice the center spin times
  // the sum of the twelve three-spin plaquette products around it.
  function automatic int flip_cost(int site);
    int x, y, z, s;
    x = site % SIDE;
    y = (site / SIDE) % SIDE;
    z = site / (SIDE * SIDE);
    s = 0;
    s += spin_of(x + 1, y, z) * spin_of(x + 1, y + 1, z) * spin_of(x, y + 1, z);
    s += spin_of(x - 1, y, z) * spin_of(x - 1, y + 1, z) * spin_of(x, y + 1, z);
    s += spin_of(x - 1, y, z) * spin_of(x - 1, y - 1, z) * spin_of(x, y - 1, z);
    s += spin_of(x + 1, y, z) * spin_of(x + 1, y - 1, z) * spin_of(x, y - 1, z);
    s += spin_of(x + 1, y, z) * spin_of(x + 1, y, z + 1) * spin_of(x, y, z + 1);
    s += spin_of(x - 1, y, z) * spin_of(x - 1, y, z + 1) * spin_of(x, y, z + 1);
    s += spin_of(x - 1, y, z) * spin_of(x - 1, y, z - 1) * spin_of(x, y, z - 1);
    s += spin_of(x + 1, y, z) * spin_of(x + 1, y, z - 1) * spin_of(x, y, z - 1);
    s += spin_of(x, y + 1, z) * spin_of(x, y + 1, z + 1) * spin_of(x, y, z + 1);
    s += spin_of(x, y - 1, z) * spin_of(x, y - 1, z - 1) * spin_of(x, y, z - 1);
    s += spin_of(x, y - 1, z) * spin_of(x, y - 1, z + 1) * spin_of(x, y, z + 1);
    s += spin_of(x, y + 1, z) * spin_of(x, y + 1, z - 1) * spin_of(x, y, z - 1);
    return 2 * s * spin_of(x, y, z);
  endfunction

  function automatic int clamp_energy(int v);
    if (v < LO_E) return LO_E;
    if (v > HI_E) return HI_E;
    return v;
  endfunction

  // Work out the result word of one accepted request and update the shadow state.
  task automatic predict_update(input request_t r);
    result_t res;
    int      delta;
    int      sum_e;
    bit      site_ok;
    bit      win;
    bit      flip;
    delta = 0;
    flip  = 1'b0;
    if (r.cmd == CMD_LOAD) begin
      n_load++;
      model_energy = r.energy;
      sum_e = model_energy;
      win = (sum_e >= win_lo) && (sum_e <= win_hi);
    end else begin
      site_ok = int'(r.site) < VOLUME;
      if (site_ok) delta = flip_cost(r.site);
      sum_e = clamp_energy(model_energy + delta);
      win = (sum_e >= win_lo) && (sum_e <= win_hi);
      if (r.cmd == CMD_RESOLVE) begin
        n_resolve++;
        if (model_attempts != '1) model_attempts++;
        if (site_ok && win && r.accept) begin
          spin_up[r.site] = ~spin_up[r.site];
          model_energy = sum_e;
          if (model_accepts != '1) model_accepts++;
          flip = 1'b1;
          n_flip++;
        end
      end else begin
        // The unused code behaves as a probe.
        n_probe++;
      end
    end
    res.delta    = DE_W'(delta);
    res.energy   = E_W'(sum_e);
    res.win      = win;
    res.flip     = flip;
    res.attempts = model_attempts;
    res.accepts  = model_accepts;
    expected_results.push_back(res);
  endtask

  task automatic queue_request(cmd_e c, int site, bit acc, int e);
    request_t r;
    r.cmd    = c;
    r.site   = SITE_W'(site);
    r.accept = acc;
    r.energy = E_W'(e);
    pending_requests.push_back(r);
  endtask

  // Random request: mostly resolves and probes on random sites, a few loads.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       e;
    pick     = $urandom_range(0, 99);
    r.site   = SITE_W'($urandom_range(0, 4095));
    r.accept = ($urandom_range(0, 3) != 0);
    r.energy = E_W'($urandom);
    if (pick < 50) begin
      r.cmd = CMD_RESOLVE;
    end else if (pick < 88) begin
      r.cmd = CMD_PROBE;
    end else if (pick < 94) begin
      r.cmd = CMD_RSVD;
    end else begin
      r.cmd = CMD_LOAD;
      case ($urandom_range(0, 9))
        0: e = LO_E;
        1: e = HI_E;
        2, 3, 4: e = $urandom;
        default: e = int'($urandom_range(0, 600)) - 300;
      endcase
      r.energy = E_W'(e);
    end
    return r;
  endfunction

  // Write both window bounds, one register per write cycle.
  task automatic set_window(int lo, int hi);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_E;
    cfg_data_i <= lo[E_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_E;
    cfg_data_i <= hi[E_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    win_lo = lo;
    win_hi = hi;
    n_windows++;
  endtask

  // Block until every queued word was sent and every result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_requests.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Driver: presents queued request words, with random gaps between them while idling is on.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_update(drv_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          drv_req = pending_requests.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.command      <= drv_req.cmd;
          in_ch.site         <= drv_req.site;
          in_ch.accept       <= drv_req.accept;
          in_ch.energy_value <= drv_req.energy;
          if (idling_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result words, with random stalls while idling is on, and compares them in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with no request outstanding");
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          n_checked++;
          if (out_ch.delta_energy_half !== exp_res.delta) begin
            $error("delta_energy_half: expected %0d, got %0d",
                   exp_res.delta, out_ch.delta_energy_half);
            error_count++;
          end
          if (out_ch.new_energy_half !== exp_res.energy) begin
            $error("new_energy_half: expected %0d, got %0d",
                   exp_res.energy, out_ch.new_energy_half);
            error_count++;
          end
          if (out_ch.in_window !== exp_res.win) begin
            $error("in_window: expected %0b, got %0b", exp_res.win, out_ch.in_window);
            error_count++;
          end
          if (out_ch.flipped !== exp_res.flip) begin
            $error("flipped: expected %0b, got %0b", exp_res.flip, out_ch.flipped);
            error_count++;
          end
          if (out_ch.attempt_count !== exp_res.attempts) begin
            $error("attempt_count: expected %0d, got %0d",
                   exp_res.attempts, out_ch.attempt_count);
            error_count++;
          end
          if (out_ch.accept_count !== exp_res.accepts) begin
            $error("accept_count: expected %0d, got %0d",
                   exp_res.accepts, out_ch.accept_count);
            error_count++;
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 15);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int lo;
    int hi;
    int span;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_PROBE;
    in_ch.site         = '0;
    in_ch.accept       = 1'b0;
    in_ch.energy_value = '0;
    out_ch.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_MIN_E;
    cfg_data_i         = '0;
    idling_on          = 1'b1;

    // Shadow state after reset: the low half in x starts spin up.
    for (int i = 0; i < VOLUME; i++) spin_up[i] = (i % SIDE) < (SIDE / 2);
    model_energy   = 0;
    model_attempts = '0;
    model_accepts  = '0;
    win_lo         = LO_E;
    win_hi         = HI_E;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset window. Site 0 sits in the up corner, so its
    // flip costs the most; that drives the energy into both clamps.
    queue_request(CMD_LOAD, 0, 1'b0, HI_E);
    queue_request(CMD_PROBE, 0, 1'b1, 0);
    queue_request(CMD_RESOLVE, 0, 1'b1, 0);
    queue_request(CMD_PROBE, 0, 1'b0, -1);
    queue_request(CMD_LOAD, 4095, 1'b1, LO_E);
    queue_request(CMD_PROBE, 0, 1'b0, 0);
    queue_request(CMD_RESOLVE, 0, 1'b0, 0);
    queue_request(CMD_RESOLVE, 0, 1'b1, 0);
    queue_request(CMD_RSVD, 4095, 1'b1, HI_E);
    queue_request(CMD_PROBE, 4095, 1'b0, LO_E);
    queue_request(CMD_LOAD, 0, 1'b0, 0);
    // Sites on either side of the initial domain wall.
    queue_request(CMD_RESOLVE, 7 + SIDE * 3 + SIDE * SIDE * 5, 1'b1, 0);
    queue_request(CMD_PROBE, 8 + SIDE * 3 + SIDE * SIDE * 5, 1'b0, 0);
    queue_request(CMD_RESOLVE, 8 + SIDE * 3 + SIDE * SIDE * 5, 1'b1, 0);
    queue_request(CMD_LOAD, 2730, 1'b1, -1);
    queue_request(CMD_RESOLVE, 4095, 1'b1, 0);
    queue_request(CMD_PROBE, 2730, 1'b1, 0);
    queue_request(CMD_RESOLVE, 1365, 1'b1, 0);
    wait_drained();

    // Empty window: nothing may flip.
    set_window(1000, -1000);
    queue_request(CMD_LOAD, 0, 1'b0, 0);
    queue_request(CMD_RESOLVE, 100, 1'b1, 0);
    queue_request(CMD_PROBE, 100, 1'b0, 0);
    wait_drained();

    // Single point window at the top, then the full range.
    set_window(HI_E, HI_E);
    queue_request(CMD_LOAD, 0, 1'b0, HI_E);
    queue_request(CMD_RESOLVE, 0, 1'b1, 0);
    queue_request(CMD_LOAD, 0, 1'b0, HI_E - 1);
    wait_drained();
    set_window(LO_E, HI_E);

    // Random phases, each under its own window; the last two run without idling.
    for (int p = 0; p < 12; p++) begin
      idling_on = (p < 10) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0, 1: begin
          lo = LO_E;
          hi = HI_E;
        end
        2, 3: begin
          span = $urandom_range(0, 80);
          lo = clamp_energy(model_energy - span);
          hi = clamp_energy(model_energy + int'($urandom_range(0, 80)));
        end
        4: begin
          lo = model_energy;
          hi = model_energy;
        end
        default: begin
          lo = $signed(18'($urandom));
          hi = $signed(18'($urandom));
        end
      endcase
      set_window(lo, hi);
      for (int n = 0; n < 150; n++) pending_requests.push_back(random_request());
      wait_drained();
    end

    // Let the core settle after the last result.
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    $display("Checked %0d result words: %0d probes, %0d resolves, %0d loads.",
             n_checked, n_probe, n_resolve, n_load);
    $display("Spins flipped: %0d; energy window settings applied: %0d.", n_flip, n_windows);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
